// ===== design/b64se_pkg.sv =====
package b64se_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SextetW = 6;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QLevelW = $clog2(QDepth + 1);

  localparam logic [7:0] PadChar = 8'h3d;

  // data characters produced from a group of one, two or three bytes: two, three or four
  localparam logic [2:0] NChars1 = 3'd2;
  localparam logic [2:0] NChars2 = 3'd3;
  localparam logic [2:0] NChars3 = 3'd4;

  // one group of up to three bytes, ready to be spelt out
  typedef struct packed {
    logic [ByteW-1:0] b0;
    logic [ByteW-1:0] b1;
    logic [ByteW-1:0] b2;
    logic [2:0]       nchars;
    logic             last;
  } grp_t;

  typedef struct packed {
    logic valid;
    grp_t grp;
  } q_push_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [QLevelW-1:0] level;
  } q_stat_t;

  function automatic logic [7:0] b64_char(input logic [SextetW-1:0] s);
    logic [7:0] c;
    if (s < 6'd26) begin
      c = 8'(8'h41 + {2'b00, s});
    end else if (s < 6'd52) begin
      c = 8'(8'h61 + {2'b00, s} - 8'd26);
    end else if (s < 6'd62) begin
      c = 8'(8'h30 + {2'b00, s} - 8'd52);
    end else if (s == 6'd62) begin
      c = 8'h2b;
    end else begin
      c = 8'h2f;
    end
    return c;
  endfunction

  function automatic logic [SextetW-1:0] grp_sextet(input grp_t g, input logic [1:0] idx);
    logic [SextetW-1:0] s;
    case (idx)
      2'd0:    s = g.b0[7:2];
      2'd1:    s = {g.b0[1:0], g.b1[7:4]};
      2'd2:    s = {g.b1[3:0], g.b2[7:6]};
      default: s = g.b2[5:0];
    endcase
    return s;
  endfunction

endpackage

// ===== design/b64se_byte_if.sv =====
interface b64se_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

// ===== design/b64se_char_if.sv =====
interface b64se_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_char;
  logic       final_char;

  modport source (output valid, output code_char, output final_char, input ready);
  modport sink (input valid, input code_char, input final_char, output ready);
endinterface

// ===== design/b64se_front.sv =====
module b64se_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  b64se_byte_if.sink        in_i,
  input  b64se_pkg::q_stat_t stat_i,
  output b64se_pkg::q_push_t push_o
);
  import b64se_pkg::*;

  logic [ByteW-1:0] hi_q, hi_d, lo_q, lo_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             acc;

  assign in_i.ready = !stat_i.full;
  assign acc        = in_i.valid && in_i.ready;

  always_comb begin
    hi_d   = hi_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    push_o = '0;
    if (acc) begin
      case (cnt_q)
        2'd0: begin
          if (in_i.final_byte) begin
            push_o.valid = 1'b1;
            push_o.grp   = '{b0: in_i.data_byte, b1: '0, b2: '0,
                             nchars: NChars1, last: 1'b1};
          end else begin
            hi_d  = in_i.data_byte;
            cnt_d = 2'd1;
          end
        end
        2'd1: begin
          if (in_i.final_byte) begin
            push_o.valid = 1'b1;
            push_o.grp   = '{b0: hi_q, b1: in_i.data_byte, b2: '0,
                             nchars: NChars2, last: 1'b1};
            cnt_d        = 2'd0;
          end else begin
            lo_d  = in_i.data_byte;
            cnt_d = 2'd2;
          end
        end
        default: begin
          // full group
          push_o.valid = 1'b1;
          push_o.grp   = '{b0: hi_q, b1: lo_q, b2: in_i.data_byte,
                           nchars: NChars3, last: in_i.final_byte};
          cnt_d        = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

endmodule

// ===== design/b64se_queue.sv =====
module b64se_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  b64se_pkg::q_push_t push_i,
  input  logic               pop_i,
  output b64se_pkg::grp_t    head_o,
  output b64se_pkg::q_stat_t stat_o
);
  import b64se_pkg::*;

  grp_t               mem_q [QDepth];
  logic [QPtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QLevelW-1:0] lvl_q, lvl_d;

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    logic [QPtrW-1:0] n;
    if (p == QPtrW'(QDepth - 1)) begin
      n = '0;
    end else begin
      n = QPtrW'(p + 1'b1);
    end
    return n;
  endfunction

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = (lvl_q == QLevelW'(QDepth));
  assign stat_o.empty = (lvl_q == '0);
  assign stat_o.level = lvl_q;

  always_comb begin
    wr_d  = push_i.valid ? ptr_inc(wr_q) : wr_q;
    rd_d  = pop_i ? ptr_inc(rd_q) : rd_q;
    lvl_d = lvl_q;
    if (push_i.valid && !pop_i) begin
      lvl_d = QLevelW'(lvl_q + 1'b1);
    end else if (!push_i.valid && pop_i) begin
      lvl_d = QLevelW'(lvl_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      lvl_q <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.grp;
    end
  end

endmodule

// ===== design/b64se_back.sv =====
module b64se_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  b64se_pkg::grp_t    head_i,
  input  b64se_pkg::q_stat_t stat_i,
  output logic               pop_o,
  b64se_char_if.source       out_o
);
  import b64se_pkg::*;

  grp_t       g_q, g_d;
  logic       busy_q, busy_d;
  logic [1:0] idx_q, idx_d;
  logic       ov_q, ov_d;
  logic [7:0] ch_q, ch_d;
  logic       fc_q, fc_d;
  logic       adv, emit;

  assign adv   = !ov_q || out_o.ready;
  assign emit  = busy_q && adv;
  assign pop_o = !stat_i.empty && (!busy_q || (emit && idx_q == 2'd3));

  always_comb begin
    g_d    = g_q;
    busy_d = busy_q;
    idx_d  = idx_q;
    ov_d   = ov_q;
    ch_d   = ch_q;
    fc_d   = fc_q;
    if (adv) begin
      ov_d = busy_q;
    end
    if (emit) begin
      // past the data characters the rest is padding
      ch_d  = ({1'b0, idx_q} < g_q.nchars) ? b64_char(grp_sextet(g_q, idx_q)) : PadChar;
      fc_d  = g_q.last && (idx_q == 2'd3);
      idx_d = 2'(idx_q + 1'b1);
      if (idx_q == 2'd3) begin
        busy_d = 1'b0;
      end
    end
    if (pop_o) begin
      g_d    = head_i;
      busy_d = 1'b1;
      idx_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    g_q  <= g_d;
    ch_q <= ch_d;
    fc_q <= fc_d;
  end

  assign out_o.valid      = ov_q;
  assign out_o.code_char  = ch_q;
  assign out_o.final_char = fc_q;

endmodule

// ===== design/base64_stream_encoder.sv =====
// channel | dir | word                          | handshake
// in_i    | in  | data_byte[7:0], final_byte    | valid / ready
// out_o   | out | code_char[7:0], final_char    | valid / ready
//
// a byte is taken every cycle while the group queue has room
// each group of three bytes (or a final partial group) gives four characters,
// one per cycle from the output register while the receiver is ready, so the
// sustained byte rate is set by the single character output port
// a completed group passes the queue, the group register, then the character register
// reset clears the byte count, queue pointers and output valid; no clearing pass
module base64_stream_encoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  b64se_byte_if.sink   in_i,
  b64se_char_if.source out_o
);
  import b64se_pkg::*;

  q_push_t push;   // group from the front, when one completes
  q_stat_t stat;   // queue occupancy
  grp_t    head;   // oldest queued group
  logic    pop;    // back takes the head group

  // front: gathers bytes into groups of three, closes a partial group on the final byte
  b64se_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .stat_i (stat),
    .push_o (push)
  );

  // short queue of whole groups between the two halves
  b64se_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (stat)
  );

  // back: spells each group out as four characters, padding where bytes are missing
  b64se_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .stat_i (stat),
    .pop_o  (pop),
    .out_o  (out_o)
  );

  // a group is never pushed into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push.valid && stat.full))
    else $error("group pushed into full queue");

  // the back only pops a queue that holds something
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

  // occupancy stays within depth
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.level <= QLevelW'(QDepth))
    else $error("queue level out of range");

  // a push with the queue idle shows up as one entry next cycle
  a_level_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.valid && !pop && stat.empty) |=> (stat.level == QLevelW'(1)))
    else $error("queue level did not follow push");

endmodule
